@@ sv/line_sensor_pid_steering_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line sensor PID steering block
// Clocked, reset-qualified property shorthands.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PID_STEERING_ASSERT_SVH
`define LINE_SENSOR_PID_STEERING_ASSERT_SVH

// cond must hold at every edge outside reset
`define LSPS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

// cons must hold at the edge after ante
`define LSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lsps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types, constants and the sensor decode for the PID steering block.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int INTEGRAL_LIMIT = 4095;
	localparam int HISTORY_DEPTH  = 3;

	// signed width of the saturating integral
	localparam int SUM_W  = $clog2(INTEGRAL_LIMIT + 1) + 1;
	// gain (9b signed) times integral, plus margin for the other two terms
	localparam int CORR_W = SUM_W + 9 + 1;

	localparam int SENS_W     = 7;
	localparam int ERR_W      = 3;
	localparam int GAIN_W     = 8;
	localparam int LIM_W      = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 3;

	localparam logic [SENS_W-1:0] SENS_NONE   = 7'h00;
	localparam logic [SENS_W-1:0] SENS_L3     = 7'h01;
	localparam logic [SENS_W-1:0] SENS_L2     = 7'h02;
	localparam logic [SENS_W-1:0] SENS_L1     = 7'h04;
	localparam logic [SENS_W-1:0] SENS_CENTER = 7'h08;
	localparam logic [SENS_W-1:0] SENS_R1     = 7'h10;
	localparam logic [SENS_W-1:0] SENS_R2     = 7'h20;
	localparam logic [SENS_W-1:0] SENS_R3     = 7'h40;

	localparam logic [GAIN_W-1:0] KP_RST   = 8'd10;
	localparam logic [GAIN_W-1:0] KI_RST   = 8'd5;
	localparam logic [GAIN_W-1:0] KD_RST   = 8'd5;
	localparam logic [LIM_W-1:0]  LIM_RST  = 10'd50;
	localparam logic [LIM_W-1:0]  BAND_RST = 10'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_PROP   = 3'd0,
		CFG_GAIN_INTEG  = 3'd1,
		CFG_GAIN_DERIV  = 3'd2,
		CFG_CLAMP_LIMIT = 3'd3,
		CFG_DEAD_BAND   = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		DRIVE_FWD = 2'd0,
		DRIVE_POS = 2'd1,
		DRIVE_NEG = 2'd2
	} drive_mode_t;

	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_RIGHT = 2'd2
	} trace_side_t;

	function automatic logic signed [ERR_W-1:0] decode_position(logic [SENS_W-1:0] r);
		logic signed [ERR_W-1:0] e;
		case (r)
			SENS_L3: e = -3'sd3;
			SENS_L2: e = -3'sd2;
			SENS_L1: e = -3'sd1;
			SENS_R1: e = 3'sd1;
			SENS_R2: e = 3'sd2;
			SENS_R3: e = 3'sd3;
			default: e = 3'sd0;
		endcase
		return e;
	endfunction

endpackage

@@ sv/lsps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_sensor_if / lsps_steer_if
// Valid/ready channels for sensor readings and steering results.
// ----------------------------------------------------------------------------
interface lsps_sensor_if import lsps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SENS_W-1:0] sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lsps_steer_if import lsps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	drive_mode_t             drive_mode;
	logic [LIM_W-1:0]        turn_amount;
	trace_side_t             traceback_side;
	logic signed [ERR_W-1:0] position_error;

	modport source (output valid, output drive_mode, output turn_amount,
		output traceback_side, output position_error, input ready);
	modport sink   (input valid, input drive_mode, input turn_amount,
		input traceback_side, input position_error, output ready);
endinterface

@@ sv/line_sensor_pid_steering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_pid_steering
// PID steering from a 7-bit line sensor, with lost-line traceback.
// ----------------------------------------------------------------------------
// One steering result per sensor reading. A reading is captured in an input
// register at the edge where its request is accepted. The result is loaded into
// the result register from the input register when the result register is empty
// or its result is being taken. A new reading is taken every clock while results
// are taken, so throughput is one item per cycle unless the output stalls. The
// rate is set by the update of the feedback state (error integral, previous
// error, reading history), which is done in the same cycle that the result
// register is loaded. The input register and the result register let a new
// request in while a finished result waits.
`include "line_sensor_pid_steering_assert.svh"

module line_sensor_pid_steering import lsps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lsps_sensor_if.sink           sensor,
	lsps_steer_if.source          steer
);

	// configuration
	logic [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [LIM_W-1:0]  clamp_limit_q, dead_band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q   <= KP_RST;
			gain_integ_q  <= KI_RST;
			gain_deriv_q  <= KD_RST;
			clamp_limit_q <= LIM_RST;
			dead_band_q   <= BAND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GAIN_PROP:   gain_prop_q   <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_INTEG:  gain_integ_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_DERIV:  gain_deriv_q  <= cfg_data[GAIN_W-1:0];
				CFG_CLAMP_LIMIT: clamp_limit_q <= cfg_data[LIM_W-1:0];
				CFG_DEAD_BAND:   dead_band_q   <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic              valid_s1;
	logic [SENS_W-1:0] sensor_s1;
	logic              out_valid_q;
	logic              advance;
	logic              in_fire;

	assign advance      = valid_s1 && (!out_valid_q || steer.ready);
	assign sensor.ready = !valid_s1 || advance;
	assign in_fire      = sensor.valid && sensor.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sensor_s1 <= sensor.sensor_bits;
		end
	end

	// feedback state
	logic [SENS_W-1:0]       history_q [HISTORY_DEPTH];
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [SUM_W-1:0] error_sum_q;

	localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(INTEGRAL_LIMIT);
	localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX;

	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W:0]    sum_raw;
	logic signed [SUM_W-1:0]  sum_next;
	logic signed [ERR_W:0]    err_diff;
	logic signed [CORR_W-1:0] p_term, i_term, d_term, corr, corr_clamped;
	logic signed [CORR_W-1:0] lim_pos, lim_neg;
	logic [LIM_W-1:0]         mag;
	drive_mode_t              mode_next;
	logic [LIM_W-1:0]         amount_next;
	trace_side_t              side_next;

	always_comb begin
		err = decode_position(sensor_s1);

		sum_raw = (SUM_W + 1)'(error_sum_q) + (SUM_W + 1)'(err);
		if (sum_raw > SUM_MAX) begin
			sum_next = SUM_W'(SUM_MAX);
		end else if (sum_raw < SUM_MIN) begin
			sum_next = SUM_W'(SUM_MIN);
		end else begin
			sum_next = SUM_W'(sum_raw);
		end

		err_diff = (ERR_W + 1)'(err) - (ERR_W + 1)'(last_error_q);

		p_term = CORR_W'($signed({1'b0, gain_prop_q})) * CORR_W'(err);
		i_term = CORR_W'($signed({1'b0, gain_integ_q})) * CORR_W'(sum_next);
		d_term = CORR_W'($signed({1'b0, gain_deriv_q})) * CORR_W'(err_diff);
		corr   = p_term + i_term + d_term;

		lim_pos = CORR_W'($signed({1'b0, clamp_limit_q}));
		lim_neg = -lim_pos;
		if (corr > lim_pos) begin
			corr_clamped = lim_pos;
		end else if (corr < lim_neg) begin
			corr_clamped = lim_neg;
		end else begin
			corr_clamped = corr;
		end

		// clamped magnitude is at most clamp_limit, so it fits LIM_W
		mag = corr_clamped[CORR_W-1] ? LIM_W'(-corr_clamped) : LIM_W'(corr_clamped);

		if (mag > dead_band_q) begin
			mode_next   = corr_clamped[CORR_W-1] ? DRIVE_NEG : DRIVE_POS;
			amount_next = mag;
		end else begin
			mode_next   = DRIVE_FWD;
			amount_next = '0;
		end

		// lost line: three empty readings in a row, oldest entry picks the side
		side_next = SIDE_NONE;
		if (sensor_s1 == SENS_NONE && history_q[0] == SENS_NONE
				&& history_q[1] == SENS_NONE) begin
			if (history_q[2] == SENS_L3 || history_q[2] == SENS_L2) begin
				side_next = SIDE_RIGHT;
			end else if (history_q[2] == SENS_R1 || history_q[2] == SENS_R2) begin
				side_next = SIDE_LEFT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				history_q[i] <= SENS_CENTER;
			end
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (advance) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				history_q[i] <= history_q[i-1];
			end
			history_q[0] <= sensor_s1;
			last_error_q <= err;
			error_sum_q  <= sum_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	drive_mode_t             drive_mode_q;
	logic [LIM_W-1:0]        turn_amount_q;
	trace_side_t             traceback_side_q;
	logic signed [ERR_W-1:0] position_error_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_mode_q     <= mode_next;
			turn_amount_q    <= amount_next;
			traceback_side_q <= side_next;
			position_error_q <= err;
		end
	end

	assign steer.valid          = out_valid_q;
	assign steer.drive_mode     = drive_mode_q;
	assign steer.turn_amount    = turn_amount_q;
	assign steer.traceback_side = traceback_side_q;
	assign steer.position_error = position_error_q;

	// checks
	`LSPS_ASSERT_ALWAYS(a_sum_bounded, clk, arst_n,
		(SUM_W + 1)'(error_sum_q) <= SUM_MAX && (SUM_W + 1)'(error_sum_q) >= SUM_MIN,
		"error integral outside saturation bounds")
	`LSPS_ASSERT_ALWAYS(a_fwd_zero, clk, arst_n,
		!out_valid_q || ((drive_mode_q == DRIVE_FWD) == (turn_amount_q == '0)),
		"turn amount disagrees with drive mode")
	`LSPS_ASSERT_NEXT(a_capture, clk, arst_n, in_fire, valid_s1,
		"accepted request not held in input stage")
	`LSPS_ASSERT_NEXT(a_last_err, clk, arst_n, advance,
		out_valid_q && last_error_q == position_error_q,
		"previous error not tracking the issued result")

endmodule
